// ===== src/uso_pkg.sv =====
// ----------------------------------------------------------------------------
// uso_pkg
// Shared types and codes for the unordered set operation engine.
// ----------------------------------------------------------------------------
package uso_pkg;

   // transaction modes
   localparam logic [2:0] MODE_INS1 = 3'd0;
   localparam logic [2:0] MODE_INS2 = 3'd1;
   localparam logic [2:0] MODE_DEL1 = 3'd2;
   localparam logic [2:0] MODE_DEL2 = 3'd3;
   localparam logic [2:0] MODE_QRY1 = 3'd4;
   localparam logic [2:0] MODE_QRY2 = 3'd5;
   localparam logic [2:0] MODE_RUN  = 3'd6;
   localparam logic [2:0] MODE_CLR  = 3'd7;

   // set operations
   localparam logic [2:0] OP_UNION = 3'd0;
   localparam logic [2:0] OP_INTER = 3'd1;
   localparam logic [2:0] OP_AMB   = 3'd2;
   localparam logic [2:0] OP_BMA   = 3'd3;
   localparam logic [2:0] OP_SYM   = 3'd4;
   localparam logic [2:0] OP_EQ    = 3'd5;

   // result status
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ELEM  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam int MAX_OUT = 32;

   // commands from controller to datapath
   typedef struct packed {
      logic       ld_req;     // capture transaction fields
      logic       scan_clr;   // restart search index
      logic       scan_sel;   // 0: scan set one, 1: set two
      logic       probe_sel;  // 0: probe from input value, 1: from outer element
      logic       scan_step;  // advance search index
      logic       outer_clr;  // restart outer index
      logic       outer_sel;  // set the outer index walks
      logic       outer_rd;   // issue read of outer entry
      logic       outer_step; // advance outer index
      logic       wr_append;  // write value at count of set
      logic       wr_move;    // write moved last entry at found slot
      logic       rd_last;    // read last entry of set
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       emit_cnt_clr;
      logic       emit_cnt_inc;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       scan_done;  // search index reached count
      logic       scan_hit;   // current entry equals probe
      logic       outer_done; // outer index reached count
      logic       full;       // set selected by request is full
      logic       emit_full;  // emission limit reached
      logic       cnt_eq;     // counts of both sets equal
   } sts_type;

endpackage

// ===== src/uso_ram.sv =====
// ----------------------------------------------------------------------------
// uso_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uso_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/uso_datapath.sv =====
// ----------------------------------------------------------------------------
// uso_datapath
// Set stores, counts, indexes and the probe compare.
// ----------------------------------------------------------------------------
module uso_datapath #(
   parameter int SET_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  uso_pkg::cmd_type    cmd,
   output uso_pkg::sts_type    sts,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_value,
   input  logic [2:0]          req_operation,
   output logic [2:0]          mode_q,
   output logic [2:0]          op_q,
   output logic [5:0]          scan_pos,
   output logic [5:0]          set_cnt,
   output logic signed [31:0]  outer_elem
);

   localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int RD = 1 << AW;

   logic [2:0]  mode_ff;
   logic [31:0] value_ff;
   logic [2:0]  op_ff;
   logic [5:0]  cnt1_ff, cnt2_ff;
   logic [5:0]  idx_ff, oidx_ff;
   logic [5:0]  emit_ff;
   logic [31:0] outer_ff;
   logic        set_sel;

   logic        wr1, wr2;
   logic [AW-1:0] wa, ra1, ra2;
   logic [31:0] wd, rd1, rd2;

   // captured transaction
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         op_ff    <= req_operation;
      end
   end
   assign mode_q  = mode_ff;
   assign op_q    = op_ff;
   assign set_sel = mode_ff[0];

   // indexes; the read address follows the index being stepped
   always_ff @(posedge clock) begin
      if (cmd.scan_clr)       idx_ff <= '0;
      else if (cmd.scan_step) idx_ff <= idx_ff + 6'd1;
      if (cmd.outer_clr)       oidx_ff <= '0;
      else if (cmd.outer_step) oidx_ff <= oidx_ff + 6'd1;
      if (cmd.emit_cnt_clr)      emit_ff <= '0;
      else if (cmd.emit_cnt_inc) emit_ff <= emit_ff + 6'd1;
   end

   // counts
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clr) begin
         cnt1_ff <= '0;
         cnt2_ff <= '0;
      end else if (cmd.cnt_inc) begin
         if (set_sel) cnt2_ff <= cnt2_ff + 6'd1;
         else         cnt1_ff <= cnt1_ff + 6'd1;
      end else if (cmd.cnt_dec) begin
         if (set_sel) cnt2_ff <= cnt2_ff - 6'd1;
         else         cnt1_ff <= cnt1_ff - 6'd1;
      end
   end

   // read address: last entry, outer walk or scan
   logic [5:0] last_idx, rd_idx;
   assign last_idx = (set_sel ? cnt2_ff : cnt1_ff) - 6'd1;
   always_comb begin
      if (cmd.rd_last)       rd_idx = last_idx;
      else if (cmd.outer_rd) rd_idx = oidx_ff;
      else                   rd_idx = idx_ff;
   end
   assign ra1 = rd_idx[AW-1:0];
   assign ra2 = rd_idx[AW-1:0];

   // writes
   always_comb begin
      wa  = cmd.wr_move ? idx_ff[AW-1:0] : set_cnt[AW-1:0];
      wd  = cmd.wr_move ? (set_sel ? rd2 : rd1) : value_ff;
      wr1 = (cmd.wr_append || cmd.wr_move) && !set_sel;
      wr2 = (cmd.wr_append || cmd.wr_move) && set_sel;
   end

   uso_ram #(.WIDTH(32), .DEPTH(RD)) u_ram1 (
      .clock(clock), .wr_en(wr1), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra1), .rd_data(rd1));
   uso_ram #(.WIDTH(32), .DEPTH(RD)) u_ram2 (
      .clock(clock), .wr_en(wr2), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra2), .rd_data(rd2));

   // outer element latch (read data arrives in the cycle after outer_rd)
   logic outer_rd_d_ff;
   always_ff @(posedge clock) begin
      outer_rd_d_ff <= cmd.outer_rd;
      if (outer_rd_d_ff) outer_ff <= cmd.outer_sel ? rd2 : rd1;
   end
   assign outer_elem = outer_ff;

   // compare of scanned entry with probe
   logic [31:0] probe, scan_data;
   logic [5:0]  scan_cnt;
   assign probe     = cmd.probe_sel ? outer_ff : value_ff;
   assign scan_data = cmd.scan_sel ? rd2 : rd1;
   assign scan_cnt  = cmd.scan_sel ? cnt2_ff : cnt1_ff;
   assign set_cnt   = set_sel ? cnt2_ff : cnt1_ff;
   assign scan_pos  = idx_ff;

   always_comb begin
      sts.scan_done  = (idx_ff >= scan_cnt);
      sts.scan_hit   = (scan_data == probe);
      sts.outer_done = (oidx_ff >= (cmd.outer_sel ? cnt2_ff : cnt1_ff));
      sts.full       = (set_cnt >= 6'(SET_DEPTH));
      sts.emit_full  = (emit_ff >= 6'(uso_pkg::MAX_OUT));
      sts.cnt_eq     = (cnt1_ff == cnt2_ff);
   end

endmodule

// ===== src/uso_ctrl.sv =====
// ----------------------------------------------------------------------------
// uso_ctrl
// Sequencer for insert, delete, query, clear and set operation runs.
// ----------------------------------------------------------------------------
module uso_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output uso_pkg::cmd_type   cmd,
   input  uso_pkg::sts_type   sts,
   input  logic [2:0]         mode_q,
   input  logic [2:0]         op_q,
   input  logic [5:0]         scan_pos,
   input  logic [5:0]         set_cnt,
   input  logic signed [31:0] outer_elem,
   output logic signed [31:0] rsp_element,
   output logic [5:0]         rsp_position,
   output logic               rsp_flag,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DISP   = 11'b00000000010,
      S_SRD    = 11'b00000000100, // single scan: address presented
      S_SCMP   = 11'b00000001000, // single scan: compare
      S_MVRD   = 11'b00000010000, // delete: read last entry
      S_MVWR   = 11'b00000100000, // delete: write moved entry
      S_ORD    = 11'b00001000000, // outer: read element
      S_OWAIT  = 11'b00010000000, // outer: data arriving
      S_ISRD   = 11'b00100000000, // inner scan: address presented
      S_ICMP   = 11'b01000000000, // inner scan: compare
      S_RESP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // run phase: phase 0 is the first pass, phase 1 the second
   logic phase_ff, phase_in;
   logic pend_ff, pend_in;      // an element waits to be emitted
   logic [31:0] pend_elem_ff, pend_elem_in;
   logic eq_ff, eq_in;
   logic [31:0] elem_ff, elem_in;
   logic [5:0]  pos_ff, pos_in;
   logic flag_ff, flag_in;
   logic [1:0] stat_ff, stat_in;
   logic last_ff, last_in;
   logic any_ff, any_in;        // any element emitted in this run
   logic after_ff, after_in;    // return to outer walk after response

   // pass description for a run: outer set, inner set, want-in
   logic outer_set, inner_set, want_in, second_pass;
   always_comb begin
      outer_set   = 1'b0;
      inner_set   = 1'b1;
      want_in     = 1'b0;
      second_pass = 1'b0;
      case (op_q)
         uso_pkg::OP_UNION: begin
            // both passes search set one: all of set one, then the rest of two
            outer_set = phase_ff; inner_set = 1'b0; want_in = !phase_ff;
            second_pass = 1'b1;
         end
         uso_pkg::OP_INTER: begin
            outer_set = 1'b1; inner_set = 1'b0; want_in = 1'b1;
         end
         uso_pkg::OP_AMB:   begin outer_set = 1'b0; inner_set = 1'b1; end
         uso_pkg::OP_BMA:   begin outer_set = 1'b1; inner_set = 1'b0; end
         uso_pkg::OP_SYM:   begin
            outer_set = phase_ff; inner_set = !phase_ff; second_pass = 1'b1;
         end
         uso_pkg::OP_EQ:    begin outer_set = 1'b0; inner_set = 1'b1; want_in = 1'b1; end
         default: ;
      endcase
   end

   logic is_run;
   assign is_run = (mode_q == uso_pkg::MODE_RUN);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      pend_elem_in = pend_elem_ff;
      eq_in        = eq_ff;
      elem_in      = elem_ff;
      pos_in       = pos_ff;
      flag_in      = flag_ff;
      stat_in      = stat_ff;
      last_in      = last_ff;
      any_in       = any_ff;
      after_in     = after_ff;
      cmd          = '0;
      cmd.outer_sel = outer_set;
      cmd.scan_sel  = is_run ? inner_set : mode_q[0];
      cmd.probe_sel = is_run;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            cmd.scan_clr     = 1'b1;
            cmd.outer_clr    = 1'b1;
            cmd.emit_cnt_clr = 1'b1;
            phase_in = 1'b0;
            pend_in  = 1'b0;
            any_in   = 1'b0;
            eq_in    = 1'b1;
            elem_in  = '0;
            pos_in   = '0;
            flag_in  = 1'b0;
            stat_in  = uso_pkg::ST_DONE;
            last_in  = 1'b1;
            after_in = 1'b0;
            if (mode_q == uso_pkg::MODE_CLR) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_RESP;
            end else if (is_run) begin
               if (op_q > uso_pkg::OP_EQ) begin
                  stat_in  = uso_pkg::ST_EMPTY;
                  state_in = S_RESP;
               end else if (op_q == uso_pkg::OP_EQ && !sts.cnt_eq) begin
                  eq_in    = 1'b0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_ORD;
               end
            end else begin
               state_in = S_SRD;
            end
         end
         // linear search of the addressed set for the request value
         S_SRD: begin
            if (sts.scan_done) begin
               // absent
               pos_in = set_cnt;
               if (mode_q == uso_pkg::MODE_INS1 || mode_q == uso_pkg::MODE_INS2) begin
                  if (sts.full) begin
                     stat_in = uso_pkg::ST_FULL;
                  end else begin
                     cmd.wr_append = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                     flag_in       = 1'b1;
                  end
               end
               state_in = S_RESP;
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (sts.scan_hit) begin
               pos_in = scan_pos;
               if (mode_q == uso_pkg::MODE_DEL1 || mode_q == uso_pkg::MODE_DEL2) begin
                  flag_in  = 1'b1;
                  state_in = S_MVRD;
               end else begin
                  flag_in  = (mode_q == uso_pkg::MODE_QRY1 ||
                              mode_q == uso_pkg::MODE_QRY2);
                  state_in = S_RESP;
               end
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_SRD;
            end
         end
         S_MVRD: begin
            cmd.rd_last = 1'b1;
            state_in    = S_MVWR;
         end
         S_MVWR: begin
            cmd.wr_move = 1'b1;
            cmd.cnt_dec = 1'b1;
            state_in    = S_RESP;
         end
         // outer walk over the emitting set
         S_ORD: begin
            if (sts.outer_done || (sts.emit_full && op_q != uso_pkg::OP_EQ)) begin
               if (second_pass && !phase_ff && !sts.emit_full) begin
                  phase_in      = 1'b1;
                  cmd.outer_clr = 1'b1;
               end else if (pend_ff) begin
                  // flush the held element as the final one
                  elem_in  = pend_elem_ff;
                  stat_in  = uso_pkg::ST_ELEM;
                  last_in  = 1'b1;
                  pend_in  = 1'b0;
                  after_in = 1'b0;
                  state_in = S_RESP;
               end else begin
                  if (op_q == uso_pkg::OP_EQ) begin
                     stat_in = uso_pkg::ST_DONE;
                  end else if (!any_ff) begin
                     stat_in = uso_pkg::ST_EMPTY;
                  end
                  last_in  = 1'b1;
                  state_in = S_RESP;
               end
            end else begin
               cmd.outer_rd = 1'b1;
               state_in     = S_OWAIT;
            end
         end
         S_OWAIT: begin
            cmd.scan_clr = 1'b1;
            state_in     = S_ISRD;
         end
         S_ISRD: begin
            if (sts.scan_done) begin
               // not a member of the inner set
               cmd.outer_step = 1'b1;
               if (op_q == uso_pkg::OP_EQ) begin
                  eq_in    = 1'b0;
                  state_in = S_RESP;
               end else if (!want_in) begin
                  state_in = S_ORD;
                  if (pend_ff) begin
                     elem_in  = pend_elem_ff;
                     stat_in  = uso_pkg::ST_ELEM;
                     last_in  = 1'b0;
                     after_in = 1'b1;
                     state_in = S_RESP;
                  end
                  pend_in          = 1'b1;
                  pend_elem_in     = outer_elem;
                  any_in           = 1'b1;
                  cmd.emit_cnt_inc = 1'b1;
               end else begin
                  state_in = S_ORD;
               end
            end else begin
               state_in = S_ICMP;
            end
         end
         S_ICMP: begin
            if (sts.scan_hit) begin
               cmd.outer_step = 1'b1;
               state_in       = S_ORD;
               if (want_in && op_q != uso_pkg::OP_EQ) begin
                  if (pend_ff) begin
                     elem_in  = pend_elem_ff;
                     stat_in  = uso_pkg::ST_ELEM;
                     last_in  = 1'b0;
                     after_in = 1'b1;
                     state_in = S_RESP;
                  end
                  pend_in          = 1'b1;
                  pend_elem_in     = outer_elem;
                  any_in           = 1'b1;
                  cmd.emit_cnt_inc = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_ISRD;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = after_ff ? S_ORD : S_IDLE;
               after_in = 1'b0;
               if (!after_ff && is_run && op_q == uso_pkg::OP_EQ) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         after_ff <= after_in;
      end
      phase_ff     <= phase_in;
      pend_elem_ff <= pend_elem_in;
      eq_ff        <= eq_in;
      elem_ff      <= elem_in;
      pos_ff       <= pos_in;
      flag_ff      <= flag_in;
      stat_ff      <= stat_in;
      last_ff      <= last_in;
      any_ff       <= any_in;
   end

   // result register
   assign rsp_valid    = (state_ff == S_RESP);
   assign rsp_element  = (stat_ff == uso_pkg::ST_ELEM) ? elem_ff : '0;
   assign rsp_position = pos_ff;
   assign rsp_flag     = (is_run && op_q == uso_pkg::OP_EQ) ? eq_ff : flag_ff;
   assign rsp_status   = stat_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== src/unordered_set_operation_engine_top.sv =====
// ----------------------------------------------------------------------------
// unordered_set_operation_engine_top
// Two unordered sets of signed 32-bit values with insert, delete, query,
// clear and set operation runs.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Insert, delete and query search the
// addressed set linearly. A run walks the emitting set and, for each entry,
// searches a set for it (union searches set one in both passes), one store
// read port per set, and each emitted element takes its own response
// handshake. The stores need no clearing after reset; only entries below
// each count are read.
module unordered_set_operation_engine_top #(
   parameter int SET_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [2:0]         req_operation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element,
   output logic [5:0]         rsp_position,
   output logic               rsp_flag,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   uso_pkg::cmd_type cmd;
   uso_pkg::sts_type sts;
   logic [2:0]  mode_q, op_q;
   logic [5:0]  scan_pos, set_cnt;
   logic signed [31:0] outer_elem;

   uso_datapath #(.SET_DEPTH(SET_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_mode(req_mode), .req_value(req_value), .req_operation(req_operation),
      .mode_q(mode_q), .op_q(op_q), .scan_pos(scan_pos), .set_cnt(set_cnt),
      .outer_elem(outer_elem));

   uso_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts), .mode_q(mode_q), .op_q(op_q),
      .scan_pos(scan_pos), .set_cnt(set_cnt), .outer_elem(outer_elem),
      .rsp_element(rsp_element), .rsp_position(rsp_position),
      .rsp_flag(rsp_flag), .rsp_status(rsp_status), .rsp_last(rsp_last));

   // no new transaction while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept during result");

   // emitted element status never carries a flag
   a_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == uso_pkg::ST_ELEM |-> !rsp_flag)
      else $error("flag on element");

   // refused insert reports the full count
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == uso_pkg::ST_FULL |-> rsp_position == 6'(SET_DEPTH))
      else $error("full position");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the unordered set operation engine against a behavioral predictor.
// Inserts, deletes, queries, clears and set-operation runs are applied with
// random gaps on both handshakes. Every response is compared field by field
// with the predicted response queue.
// ----------------------------------------------------------------------------

// predicted response record
typedef struct packed {
   logic signed [31:0] element;
   logic [5:0]         position;
   logic               flag;
   logic [1:0]         status;
   logic               last;
} set_rsp_type;

class set_scoreboard;
   localparam int DEPTH = 16;
   logic signed [31:0] store_one [DEPTH];
   logic signed [31:0] store_two [DEPTH];
   int count_one;
   int count_two;
   set_rsp_type pending[$];
   int errors;
   int checked;
   int emitted;

   function new();
      count_one = 0;
      count_two = 0;
      errors = 0;
      checked = 0;
      emitted = 0;
   endfunction

   function int locate(bit second, logic signed [31:0] v);
      int n;
      n = second ? count_two : count_one;
      for (int i = 0; i < n; i++) begin
         if ((second ? store_two[i] : store_one[i]) == v) return i;
      end
      return n;
   endfunction

   function void push(logic signed [31:0] e, int pos, bit f, logic [1:0] st);
      set_rsp_type r;
      r.element = e;
      r.position = pos[5:0];
      r.flag = f;
      r.status = st;
      r.last = 1'b1;
      pending.push_back(r);
   endfunction

   // emit entries of one set whose membership in a searched set equals want_in
   function int filter(bit src_two, bit in_two, bit want_in, int k);
      int n;
      logic signed [31:0] e;
      set_rsp_type r;
      n = src_two ? count_two : count_one;
      for (int i = 0; i < n; i++) begin
         e = src_two ? store_two[i] : store_one[i];
         if (((locate(in_two, e) < (in_two ? count_two : count_one))) == want_in
             && k < uso_pkg::MAX_OUT) begin
            r = '{element: e, position: 6'd0, flag: 1'b0, status: uso_pkg::ST_ELEM,
                  last: 1'b0};
            pending.push_back(r);
            k++;
         end
      end
      return k;
   endfunction

   // note an accepted request and queue its responses
   function void note_request(logic [2:0] mode, logic signed [31:0] v, logic [2:0] op);
      bit second;
      int pos;
      int cnt;
      int k;
      bit same;
      second = mode[0];
      cnt = second ? count_two : count_one;
      k = 0;
      if (mode == uso_pkg::MODE_INS1 || mode == uso_pkg::MODE_INS2) begin
         pos = locate(second, v);
         if (pos < cnt) push(0, pos, 0, uso_pkg::ST_DONE);
         else if (cnt >= DEPTH) push(0, cnt, 0, uso_pkg::ST_FULL);
         else begin
            if (second) store_two[cnt] = v; else store_one[cnt] = v;
            if (second) count_two++; else count_one++;
            push(0, cnt, 1, uso_pkg::ST_DONE);
         end
      end else if (mode == uso_pkg::MODE_DEL1 || mode == uso_pkg::MODE_DEL2) begin
         pos = locate(second, v);
         if (pos < cnt) begin
            if (second) begin
               store_two[pos] = store_two[cnt-1];
               count_two--;
            end else begin
               store_one[pos] = store_one[cnt-1];
               count_one--;
            end
            push(0, pos, 1, uso_pkg::ST_DONE);
         end else push(0, cnt, 0, uso_pkg::ST_DONE);
      end else if (mode == uso_pkg::MODE_QRY1 || mode == uso_pkg::MODE_QRY2) begin
         pos = locate(second, v);
         push(0, pos, pos < cnt, uso_pkg::ST_DONE);
      end else if (mode == uso_pkg::MODE_CLR) begin
         count_one = 0;
         count_two = 0;
         push(0, 0, 0, uso_pkg::ST_DONE);
      end else begin
         case (op)
            uso_pkg::OP_UNION: begin
               k = filter(0, 0, 1, k);
               k = filter(1, 0, 0, k);
            end
            uso_pkg::OP_INTER: k = filter(1, 0, 1, k);
            uso_pkg::OP_AMB:   k = filter(0, 1, 0, k);
            uso_pkg::OP_BMA:   k = filter(1, 0, 0, k);
            uso_pkg::OP_SYM: begin
               k = filter(0, 1, 0, k);
               k = filter(1, 0, 0, k);
            end
            uso_pkg::OP_EQ: begin
               same = (count_one == count_two);
               for (int i = 0; same && i < count_one; i++)
                  if (locate(1, store_one[i]) >= count_two) same = 0;
               push(0, 0, same, uso_pkg::ST_DONE);
               return;
            end
            default: ;
         endcase
         emitted += k;
         if (k == 0) push(0, 0, 0, uso_pkg::ST_EMPTY);
         else pending[$].last = 1'b1;
      end
   endfunction

   // compare a response with the oldest prediction
   function void check_response(set_rsp_type got);
      set_rsp_type exp;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected response element=%0d status=%0d", got.element, got.status);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.element !== exp.element) begin
         $error("element: expected %0d, got %0d", exp.element, got.element);
         errors++;
      end
      if (got.position !== exp.position) begin
         $error("position: expected %0d, got %0d", exp.position, got.position);
         errors++;
      end
      if (got.flag !== exp.flag) begin
         $error("flag: expected %0d, got %0d", exp.flag, got.flag);
         errors++;
      end
      if (got.status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, got.status);
         errors++;
      end
      if (got.last !== exp.last) begin
         $error("last: expected %0d, got %0d", exp.last, got.last);
         errors++;
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic [2:0]         req_operation;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_element;
   logic [5:0]         rsp_position;
   logic               rsp_flag;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   set_scoreboard sb;
   logic signed [31:0] pool [8];
   int idle_cycles;
   int sent;

   unordered_set_operation_engine_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_value(req_value), .req_operation(req_operation),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_element(rsp_element),
      .rsp_position(rsp_position), .rsp_flag(rsp_flag), .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one transaction and wait for its acceptance
   task automatic send_request(logic [2:0] mode, logic signed [31:0] v, logic [2:0] op);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= v;
      req_operation <= op;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, v, op);
      sent++;
   endtask

   task automatic pause_request(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_gapped(logic [2:0] mode, logic signed [31:0] v, logic [2:0] op);
      int g;
      g = gap_len();
      if (g > 0) pause_request(g);
      send_request(mode, v, op);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // response side: random back-pressure, check at each accepted response
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_element, rsp_position, rsp_flag, rsp_status, rsp_last});
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else if (!reset) idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int r;
      logic [2:0] m;
      sb = new();
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = uso_pkg::MODE_INS1;
      req_value = '0;
      req_operation = uso_pkg::OP_UNION;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty sets, extremes, duplicates, full set, every operation
      send_request(uso_pkg::MODE_QRY1, 32'sh8000_0000, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_DEL2, 32'sh7fff_ffff, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_RUN, 0, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_RUN, 0, uso_pkg::OP_EQ);
      send_request(uso_pkg::MODE_INS1, 32'sh8000_0000, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_INS1, 32'sh7fff_ffff, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_INS1, 32'sh7fff_ffff, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_INS2, -1, 3'd7);
      send_request(uso_pkg::MODE_INS2, 32'sh7fff_ffff, 3'd6);
      for (int i = 0; i < 6; i++)
         send_request(uso_pkg::MODE_RUN, 32'shffff_ffff, i[2:0]);
      send_request(uso_pkg::MODE_RUN, 0, 3'd6);
      send_request(uso_pkg::MODE_RUN, 0, 3'd7);
      for (int i = 0; i < 15; i++)
         send_request(uso_pkg::MODE_INS1, i * 3 + 1, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_INS2, 0, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_QRY2, -1, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_DEL1, 32'sh8000_0000, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_RUN, 0, uso_pkg::OP_UNION);
      send_request(uso_pkg::MODE_CLR, 0, uso_pkg::OP_UNION);

      // sender holds off until every response has arrived
      drain();

      // random: grow sets from a small value pool so overlaps are common
      for (int b = 0; b < 12; b++) begin
         for (int i = 0; i < 8; i++) pool[i] = (b % 3 == 0) ? $urandom : $urandom_range(0, 20);
         for (int i = 0; i < 33; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) m = 3'($urandom_range(0, 1));
            else if (r < 55) m = 3'($urandom_range(2, 3));
            else if (r < 70) m = 3'($urandom_range(4, 5));
            else if (r < 97) m = uso_pkg::MODE_RUN;
            else m = uso_pkg::MODE_CLR;
            send_gapped(m, pick_value(), 3'($urandom_range(0, 7)));
         end
         if (b == 5) drain();
      end
      // fill both sets to capacity for wide runs
      for (int i = 0; i < 18; i++) send_gapped(uso_pkg::MODE_INS1, $urandom, uso_pkg::OP_UNION);
      for (int i = 0; i < 18; i++) send_gapped(uso_pkg::MODE_INS2, $urandom, uso_pkg::OP_UNION);
      send_gapped(uso_pkg::MODE_RUN, 0, uso_pkg::OP_UNION);
      send_gapped(uso_pkg::MODE_RUN, 0, uso_pkg::OP_SYM);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("run covered %0d requests, %0d responses, %0d emitted elements",
               sent, sb.checked, sb.emitted);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
